// ----- src/tts_pkg.sv -----
// Shared types and constants for the task table scheduler.
// Depends on nothing; every other file imports it.
package tts_pkg;

   localparam int REQ_W      = 2;
   localparam int HANDLE_W   = 8;
   localparam int TIME_W     = 16;
   localparam int DEL_SLOT_W = 3;
   localparam int KIND_W     = 2;
   localparam int IDX_W      = 4;
   localparam int PEND_W     = 8;
   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK     = 2'd0,
      REQ_ADD      = 2'd1,
      REQ_DELETE   = 2'd2,
      REQ_DISPATCH = 2'd3
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_RUN    = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_DONE   = 2'd3
   } rsp_kind_type;

   // one task slot
   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   countdown;
      logic [TIME_W-1:0]   period;
      logic                coop;
      logic [PEND_W-1:0]   pending;
   } slot_type;

   // control into the head update unit
   typedef struct packed {
      req_code_type op;
      logic         del_hit;
      logic         add_open;
   } proc_ctrl_type;

   // status out of the head update unit
   typedef struct packed {
      logic emit;
      logic claimed;
      logic present;
   } proc_stat_type;

endpackage

// ----- src/tts_cell.sv -----
// One cell of the slot ring: holds a single task slot and takes its
// neighbor's slot on every shift. Depends on tts_pkg.
module tts_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  tts_pkg::slot_type slot_d,
   output tts_pkg::slot_type slot_q
);
   import tts_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = shift ? slot_d : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_q = slot_ff;

endmodule

// ----- src/tts_proc.sv -----
// Update unit at the head of the slot ring: applies one request to the
// slot leaving cell 0 before it re-enters at the tail. Depends on tts_pkg.
module tts_proc (
   input  tts_pkg::proc_ctrl_type ctrl,
   input  tts_pkg::slot_type      slot_d,
   input  tts_pkg::slot_type      fresh,
   output tts_pkg::slot_type      slot_q,
   output tts_pkg::proc_stat_type stat
);
   import tts_pkg::*;

   always_comb begin
      slot_q = slot_d;
      stat   = '0;
      case (ctrl.op)
         REQ_TICK: begin
            if (slot_d.valid) begin
               if (slot_d.countdown == '0) begin
                  if (slot_d.coop) begin
                     if (slot_d.pending != PEND_MAX) begin
                        slot_q.pending = slot_d.pending + PEND_W'(1);
                     end
                  end else begin
                     stat.emit = 1'b1;
                     if (slot_d.period == '0) begin
                        slot_q.valid = 1'b0;
                     end
                  end
                  if (slot_d.period != '0) begin
                     slot_q.countdown = slot_d.period;
                  end
               end else begin
                  slot_q.countdown = slot_d.countdown - TIME_W'(1);
               end
            end
         end
         REQ_ADD: begin
            if (ctrl.add_open && !slot_d.valid) begin
               slot_q       = fresh;
               stat.claimed = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (ctrl.del_hit) begin
               stat.present = slot_d.valid;
               slot_q       = '0;
            end
         end
         REQ_DISPATCH: begin
            if (slot_d.valid && slot_d.coop && slot_d.pending != '0) begin
               stat.emit      = 1'b1;
               slot_q.pending = slot_d.pending - PEND_W'(1);
               if (slot_d.period == '0) begin
                  slot_q.valid = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- src/task_table_scheduler.sv -----
// Task table scheduler: a ring of SLOTS task slots with time-triggered
// pre-emptive and cooperative runs. Depends on tts_pkg, tts_cell, tts_proc.
//
// Use: drive req_* and raise start; a transfer happens at an edge with start
// high and busy low. Every request (tick, add, delete, dispatch) rotates the
// ring once: each slot in turn passes the update unit from cell 0 and
// re-enters at the tail, then the closing result is made.
// Results come out on rsp_* marked by rsp_valid, one cycle each, in slot
// order. Tick gives one run result per pre-emptive task due (a due
// cooperative task gains a pending run instead), dispatch one per cooperative
// task with a pending run; each then gives a walk done result with rsp_last
// high; add and delete give a single reply. A run result is registered and
// shows in the cycle after the slot's turn. A new request is not taken until
// the ring rotation and the closing step are done; busy drops with the closing
// result, so the next request can be taken at the edge that ends that cycle.
// The receiver cannot stall: results are never held back.
// Reset (synchronous, active high) empties every slot and returns to idle.
module task_table_scheduler #(
   parameter int SLOTS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tts_pkg::REQ_W-1:0]        req_type,
   input  logic [tts_pkg::HANDLE_W-1:0]     req_task_handle,
   input  logic [tts_pkg::TIME_W-1:0]       req_start_delay,
   input  logic [tts_pkg::TIME_W-1:0]       req_repeat_period,
   input  logic                             req_cooperative,
   input  logic [tts_pkg::DEL_SLOT_W-1:0]   req_slot,
   output logic                             rsp_valid,
   output logic [tts_pkg::KIND_W-1:0]       rsp_kind,
   output logic [tts_pkg::IDX_W-1:0]        rsp_slot_index,
   output logic [tts_pkg::HANDLE_W-1:0]     rsp_run_handle,
   output logic                             rsp_was_present,
   output logic                             rsp_last
);
   import tts_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);
   localparam int MW = (CW > DEL_SLOT_W) ? CW : DEL_SLOT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           step_ff, step_in;
   logic [CW-1:0]           add_idx_ff, add_idx_in;
   logic                    found_ff, found_in;
   logic                    present_ff, present_in;
   req_code_type            op_ff, op_in;
   slot_type                fresh_ff, fresh_in;
   logic [DEL_SLOT_W-1:0]   del_slot_ff, del_slot_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_kind_type            rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [HANDLE_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic                    rsp_present_ff, rsp_present_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    shift;
   slot_type                cell_q [SLOTS];
   slot_type                head_q;
   proc_ctrl_type           ctrl;
   proc_stat_type           stat;

   // ring: cell k takes from cell k+1, the tail takes the updated head
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      slot_type cell_d;
      if (k == SLOTS - 1) begin : g_tail
         assign cell_d = head_q;
      end else begin : g_mid
         assign cell_d = cell_q[k+1];
      end
      tts_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .shift  (shift),
         .slot_d (cell_d),
         .slot_q (cell_q[k])
      );
   end

   always_comb begin
      ctrl.op       = op_ff;
      ctrl.del_hit  = (MW'(del_slot_ff) == MW'(step_ff));
      ctrl.add_open = !found_ff;
   end

   tts_proc u_proc (
      .ctrl   (ctrl),
      .slot_d (cell_q[0]),
      .fresh  (fresh_ff),
      .slot_q (head_q),
      .stat   (stat)
   );

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      add_idx_in     = add_idx_ff;
      found_in       = found_ff;
      present_in     = present_ff;
      op_in          = op_ff;
      fresh_in       = fresh_ff;
      del_slot_in    = del_slot_ff;
      shift          = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in             = req_code_type'(req_type);
               fresh_in.valid     = 1'b1;
               fresh_in.handle    = req_task_handle;
               fresh_in.countdown = req_start_delay;
               fresh_in.period    = req_repeat_period;
               fresh_in.coop      = req_cooperative;
               fresh_in.pending   = '0;
               del_slot_in       = req_slot;
               step_in           = '0;
               found_in          = 1'b0;
               present_in        = 1'b0;
               state_in          = ST_WALK;
            end
         end
         ST_WALK: begin
            shift = 1'b1;
            if (stat.emit) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_RUN;
               rsp_idx_in     = IDX_W'(step_ff);
               rsp_handle_in  = cell_q[0].handle;
               rsp_present_in = 1'b0;
               rsp_last_in    = 1'b0;
            end
            if (stat.claimed) begin
               found_in   = 1'b1;
               add_idx_in = step_ff;
            end
            if (stat.present) begin
               present_in = 1'b1;
            end
            if (step_ff == CW'(SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_last_in    = 1'b1;
            rsp_handle_in  = '0;
            rsp_present_in = 1'b0;
            case (op_ff)
               REQ_ADD: begin
                  rsp_kind_in = KIND_ADD;
                  rsp_idx_in  = found_ff ? IDX_W'(add_idx_ff) : IDX_W'(SLOTS);
               end
               REQ_DELETE: begin
                  rsp_kind_in    = KIND_DELETE;
                  rsp_idx_in     = IDX_W'(del_slot_ff);
                  rsp_present_in = present_ff;
               end
               default: begin
                  rsp_kind_in = KIND_DONE;
                  rsp_idx_in  = '0;
               end
            endcase
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      add_idx_ff     <= add_idx_in;
      found_ff       <= found_in;
      present_ff     <= present_in;
      op_ff          <= op_in;
      fresh_ff       <= fresh_in;
      del_slot_ff    <= del_slot_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_slot_index  = rsp_idx_ff;
   assign rsp_run_handle  = rsp_handle_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- src/tts_checker.sv -----
// Port-level checks for the task table scheduler, bound to its top level.
// Depends on tts_pkg and task_table_scheduler.
module tts_prop_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [tts_pkg::KIND_W-1:0]   rsp_kind,
   input logic                         rsp_last
);
   import tts_pkg::*;

   // a transfer always starts a walk
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer did not raise busy");

   // run events never close a request
   a_run_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RUN |-> !rsp_last)
      else $error("run event marked last");

   // add and delete replies are single results
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ADD || rsp_kind == KIND_DELETE) |-> rsp_last)
      else $error("reply not marked last");

   // the closing result frees the block in the same cycle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy with the closing result");

   // no result comes straight after a closing result
   a_last_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after closing result");

endmodule

bind task_table_scheduler tts_prop_checker u_tts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_kind  (rsp_kind),
   .rsp_last  (rsp_last)
);
